// File: src/ial_pkg.sv
`default_nettype none

package ial_pkg;

    localparam int CAPACITY     = 16;
    localparam int ELEMENT_BITS = 32;
    localparam int POS_W        = 4;
    localparam int COUNT_W      = 5;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        opcode_t                 opcode;
        logic [POS_W-1:0]        position;
        logic [ELEMENT_BITS-1:0] element_value;
    } in_t;

    typedef struct packed {
        status_t                 status;
        logic [ELEMENT_BITS-1:0] data_out;
        logic [COUNT_W-1:0]      fill_level;
        logic                    is_empty;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    insert;
        logic    remove;
        logic    clear;
        logic    take_data;
        status_t status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [COUNT_W-1:0] count;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/ial_ctrl.sv
`default_nettype none

module ial_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ial_pkg::opcode_t opcode,
    input  wire logic [ial_pkg::POS_W-1:0] position,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire ial_pkg::dp_stat_t dp_stat,
    output ial_pkg::cmd_t         cmd
);

    typedef enum logic {
        S_EMPTY,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   in_range;
    logic   ins_range;
    logic   full;

    assign s_ready = (state_reg == S_EMPTY) || m_ready;
    assign m_valid = (state_reg == S_HOLD);
    assign accept  = s_valid && s_ready;

    assign in_range  = {1'b0, position} < dp_stat.count;
    assign ins_range = {1'b0, position} <= dp_stat.count;
    assign full      = dp_stat.count == ial_pkg::COUNT_W'(ial_pkg::CAPACITY);

    always_comb begin
        cmd         = '0;
        cmd.capture = accept;
        cmd.status  = ial_pkg::ST_DONE;
        unique case (opcode)
            ial_pkg::OP_READ: begin
                if (in_range) begin
                    cmd.take_data = 1'b1;
                end else begin
                    cmd.status = ial_pkg::ST_RANGE;
                end
            end
            ial_pkg::OP_INSERT: begin
                if (full) begin
                    cmd.status = ial_pkg::ST_FULL;
                end else if (!ins_range) begin
                    cmd.status = ial_pkg::ST_RANGE;
                end else begin
                    cmd.insert = accept;
                end
            end
            ial_pkg::OP_DELETE: begin
                if (in_range) begin
                    cmd.take_data = 1'b1;
                    cmd.remove    = accept;
                end else begin
                    cmd.status = ial_pkg::ST_RANGE;
                end
            end
            ial_pkg::OP_CLEAR: begin
                cmd.clear = accept;
            end
            default: cmd.status = ial_pkg::ST_DONE;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = S_HOLD;
        end else if (m_ready) begin
            state_next = S_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: src/ial_datapath.sv
`default_nettype none

module ial_datapath (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire ial_pkg::in_t   in_item,
    input  wire ial_pkg::cmd_t  cmd,
    output ial_pkg::dp_stat_t   dp_stat,
    output ial_pkg::out_t       result
);

    logic [ial_pkg::ELEMENT_BITS-1:0] cells_reg [ial_pkg::CAPACITY];
    logic [ial_pkg::COUNT_W-1:0]      count_reg;
    logic [ial_pkg::COUNT_W-1:0]      count_next;
    ial_pkg::out_t                    result_reg;
    ial_pkg::out_t                    result_next;

    assign dp_stat.count = count_reg;
    assign result        = result_reg;

    always_comb begin
        count_next = count_reg;
        if (cmd.clear) begin
            count_next = '0;
        end else if (cmd.insert) begin
            count_next = count_reg + ial_pkg::COUNT_W'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - ial_pkg::COUNT_W'(1);
        end
    end

    always_comb begin
        result_next.status     = cmd.status;
        result_next.data_out   = cmd.take_data ? cells_reg[in_item.position] : '0;
        result_next.fill_level = count_next;
        result_next.is_empty   = (count_next == '0);
    end

    // each cell shifts or holds on its own compare against the position
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ial_pkg::CAPACITY; i++) begin
            if (cmd.insert) begin
                if (ial_pkg::POS_W'(i) == in_item.position) begin
                    cells_reg[i] <= in_item.element_value;
                end else if (i > 0 && ial_pkg::POS_W'(i) > in_item.position) begin
                    cells_reg[i] <= cells_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (cmd.remove) begin
                if (i < ial_pkg::CAPACITY - 1 && ial_pkg::POS_W'(i) >= in_item.position) begin
                    cells_reg[i] <= cells_reg[(i < ial_pkg::CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

// File: src/indexed_array_list_core.sv
`default_nettype none

// Ordered list of up to 16 words with read, insert, delete and clear at a
// list index. Every operation completes in the cycle its input transfer is
// taken: all cells shift or hold at once, each on its own position compare,
// so one operation is accepted per cycle while the result channel
// keeps up. A single output register holds each result; s_ready drops only
// while that register is full and m_ready is low. Rejected operations leave
// the list unchanged and report full or out of range in the status field.
module indexed_array_list_core (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ial_pkg::in_t  s_payload,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ial_pkg::out_t      m_payload
);

    ial_pkg::cmd_t     cmd;
    ial_pkg::dp_stat_t dp_stat;

    ial_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .opcode   (s_payload.opcode),
        .position (s_payload.position),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .dp_stat  (dp_stat),
        .cmd      (cmd)
    );

    ial_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_payload),
        .cmd      (cmd),
        .dp_stat  (dp_stat),
        .result   (m_payload)
    );

endmodule

`default_nettype wire

// File: src/ial_checker.sv
`default_nettype none

module ial_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_valid,
    input wire logic          s_ready,
    input wire ial_pkg::in_t  s_payload,
    input wire logic          m_valid,
    input wire logic          m_ready,
    input wire ial_pkg::out_t m_payload
);

    // stalled result transfer holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transfer gave no result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_payload.is_empty == (m_payload.fill_level == '0)) &&
                    (m_payload.fill_level <= ial_pkg::COUNT_W'(ial_pkg::CAPACITY)))
        else $error("fill level inconsistent");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status == ial_pkg::ST_FULL |->
            m_payload.fill_level == ial_pkg::COUNT_W'(ial_pkg::CAPACITY) &&
            m_payload.data_out == '0)
        else $error("full status on a list that is not full");

    // clear always succeeds with an empty list
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.opcode == ial_pkg::OP_CLEAR |=>
            m_payload.is_empty && m_payload.status == ial_pkg::ST_DONE)
        else $error("clear left entries");

endmodule

bind indexed_array_list_core ial_checker u_ial_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire

// File: tb/sv/tb_indexed_array_list_core.sv
module tb_indexed_array_list_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        ial_pkg::in_t  op;
        int            reps;
        bit            typed;
        ial_pkg::out_t want;
    } dir_row_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    ial_pkg::in_t  s_payload = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    ial_pkg::out_t m_payload;

    logic [ial_pkg::ELEMENT_BITS-1:0] shadow_words [ial_pkg::CAPACITY];
    int unsigned                      shadow_len = 0;

    ial_pkg::out_t pending_results [$];
    dir_row_t      directed_rows [$];
    int            mismatch_count = 0;
    int            burst_left = 0;

    indexed_array_list_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic ial_pkg::out_t apply_list_op(input ial_pkg::in_t op);
        ial_pkg::out_t r;
        int unsigned   p;
        int unsigned   i;
        r = '0;
        r.status = ial_pkg::ST_DONE;
        p = op.position;
        case (op.opcode)
            ial_pkg::OP_READ: begin
                if (p < shadow_len)
                    r.data_out = shadow_words[p];
                else
                    r.status = ial_pkg::ST_RANGE;
            end
            ial_pkg::OP_INSERT: begin
                if (shadow_len >= ial_pkg::CAPACITY) begin
                    r.status = ial_pkg::ST_FULL;
                end else if (p > shadow_len) begin
                    r.status = ial_pkg::ST_RANGE;
                end else begin
                    for (i = shadow_len; i > p; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[p] = op.element_value;
                    shadow_len++;
                end
            end
            ial_pkg::OP_DELETE: begin
                if (p < shadow_len) begin
                    r.data_out = shadow_words[p];
                    for (i = p; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end else begin
                    r.status = ial_pkg::ST_RANGE;
                end
            end
            ial_pkg::OP_CLEAR: begin
                shadow_len = 0;
            end
        endcase
        r.fill_level = ial_pkg::COUNT_W'(shadow_len);
        r.is_empty   = (shadow_len == 0);
        return r;
    endfunction

    function automatic ial_pkg::in_t make_random_op(input bit grow);
        ial_pkg::in_t op;
        int unsigned  roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
            op.opcode = ial_pkg::OP_CLEAR;
        else if (roll < (grow ? 62 : 27))
            op.opcode = ial_pkg::OP_INSERT;
        else if (roll < (grow ? 77 : 72))
            op.opcode = ial_pkg::OP_DELETE;
        else
            op.opcode = ial_pkg::OP_READ;

        case ($urandom_range(0, 9))
            0:       op.element_value = '1;
            1:       op.element_value = '0;
            default: op.element_value = $urandom;
        endcase

        if ($urandom_range(0, 99) < 12)
            op.position = ial_pkg::POS_W'($urandom_range(0, ial_pkg::CAPACITY-1));
        else if (op.opcode == ial_pkg::OP_INSERT)
            op.position = ial_pkg::POS_W'($urandom_range(0,
                              shadow_len > ial_pkg::CAPACITY-1 ?
                              ial_pkg::CAPACITY-1 : shadow_len));
        else if (shadow_len > 0)
            op.position = ial_pkg::POS_W'($urandom_range(0, shadow_len-1));
        else
            op.position = ial_pkg::POS_W'($urandom_range(0, ial_pkg::CAPACITY-1));
        return op;
    endfunction

    task automatic add_row(input ial_pkg::opcode_t oc, input int pos,
                           input logic [31:0] val, input int reps, input bit typed,
                           input ial_pkg::status_t st, input logic [31:0] data,
                           input int lvl);
        dir_row_t row;
        row.op.opcode        = oc;
        row.op.position      = ial_pkg::POS_W'(pos);
        row.op.element_value = val;
        row.reps             = reps;
        row.typed            = typed;
        row.want.status      = st;
        row.want.data_out    = data;
        row.want.fill_level  = ial_pkg::COUNT_W'(lvl);
        row.want.is_empty    = (lvl == 0);
        directed_rows.push_back(row);
    endtask

    // bursts of transfers separated by random gaps
    task automatic send_op(input ial_pkg::in_t op, input bit typed,
                           input ial_pkg::out_t typed_want);
        ial_pkg::out_t predicted;
        int            gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= op;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_list_op(op);
        pending_results.push_back(typed ? typed_want : predicted);
    endtask

    initial begin
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        ial_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: status=%0d data=%h level=%0d empty=%0b",
                             m_payload.status, m_payload.data_out,
                             m_payload.fill_level, m_payload.is_empty);
            end else begin
                want = pending_results.pop_front();
                if (m_payload.status !== want.status || m_payload.data_out !== want.data_out ||
                    m_payload.fill_level !== want.fill_level ||
                    m_payload.is_empty !== want.is_empty) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp status=%0d data=%h level=%0d empty=%0b, %s",
                                 want.status, want.data_out, want.fill_level, want.is_empty,
                                 $sformatf("got status=%0d data=%h level=%0d empty=%0b",
                                           m_payload.status, m_payload.data_out,
                                           m_payload.fill_level, m_payload.is_empty));
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        dir_row_t     row;
        ial_pkg::in_t op;
        int           k;
        int           n;
        int           mode_left;
        bit           grow;

        add_row(ial_pkg::OP_READ,    0, 32'h0000_0000,  1, 1, ial_pkg::ST_RANGE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_DELETE, 15, 32'h0000_0000,  1, 1, ial_pkg::ST_RANGE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_INSERT,  1, 32'h1234_5678,  1, 1, ial_pkg::ST_RANGE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_CLEAR,   0, 32'h0000_0000,  1, 1, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_INSERT,  0, 32'hFFFF_FFFF,  1, 1, ial_pkg::ST_DONE,
                32'h0000_0000,  1);
        add_row(ial_pkg::OP_INSERT,  0, 32'h0000_0000,  1, 1, ial_pkg::ST_DONE,
                32'h0000_0000,  2);
        add_row(ial_pkg::OP_READ,    1, 32'h0000_0000,  1, 1, ial_pkg::ST_DONE,
                32'hFFFF_FFFF,  2);
        add_row(ial_pkg::OP_INSERT,  2, 32'hA5A5_A5A5,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_INSERT,  1, 32'h5A5A_5A5A,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_READ,    3, 32'h0000_0000,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_READ,    4, 32'h0000_0000,  1, 1, ial_pkg::ST_RANGE,
                32'h0000_0000,  4);
        add_row(ial_pkg::OP_INSERT,  5, 32'h0F0F_0F0F,  1, 1, ial_pkg::ST_RANGE,
                32'h0000_0000,  4);
        add_row(ial_pkg::OP_DELETE,  1, 32'h0000_0000,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_DELETE,  2, 32'h0000_0000,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_INSERT,  1, 32'h1000_0000, 14, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_INSERT,  8, 32'h7777_7777,  1, 1, ial_pkg::ST_FULL,
                32'h0000_0000, 16);
        add_row(ial_pkg::OP_INSERT, 15, 32'h8888_8888,  1, 1, ial_pkg::ST_FULL,
                32'h0000_0000, 16);
        add_row(ial_pkg::OP_READ,   15, 32'h0000_0000,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_DELETE, 15, 32'h0000_0000,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_INSERT, 15, 32'hDEAD_BEEF,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_DELETE,  0, 32'h0000_0000,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_READ,   14, 32'h0000_0000,  1, 0, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_CLEAR,   9, 32'h0000_0000,  1, 1, ial_pkg::ST_DONE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_READ,    0, 32'h0000_0000,  1, 1, ial_pkg::ST_RANGE,
                32'h0000_0000,  0);
        add_row(ial_pkg::OP_INSERT,  0, 32'h8000_0001,  1, 1, ial_pkg::ST_DONE,
                32'h0000_0000,  1);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            row = directed_rows[r];
            for (k = 0; k < row.reps; k++) begin
                op = row.op;
                op.element_value = op.element_value + ial_pkg::ELEMENT_BITS'(k);
                send_op(op, row.typed, row.want);
            end
        end

        // alternate between phases that fill and drain the list
        grow      = 1'b0;
        mode_left = 0;
        for (n = 0; n < 1900; n++) begin
            if (mode_left == 0) begin
                grow      = !grow;
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            send_op(make_random_op(grow), 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
